/* hdl/sha_pkg.sv */
`default_nettype none
package sha_pkg;
	localparam int WordW = 32;
	localparam int Rounds = 64;
	localparam int BlockWords = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PACK,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} round_ctl_t;

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return k[t];
	endfunction

	function automatic logic [255:0] init_h();
		return {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	endfunction
endpackage
`default_nettype wire

/* hdl/sha_in_if.sv */
`default_nettype none
interface sha_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	modport source (output valid, func, data_word, byte_count, input ready);
	modport sink (input valid, func, data_word, byte_count, output ready);
endinterface
`default_nettype wire

/* hdl/sha_out_if.sv */
`default_nettype none
interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

/* hdl/sha_round.sv */
`default_nettype none
// one compression round per cycle over a rolling 16-word schedule window
module sha_round import sha_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire round_ctl_t   ctl_in,
	input  wire logic [511:0] block,
	input  wire logic [255:0] chain,
	output round_ctl_t        ctl_out,
	output logic [255:0]      vars
);
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [5:0]  t_q;
	logic        busy_q;
	logic        done_q;

	logic [31:0] w_new, s0, s1, t1, t2, e1, a0, ch, maj;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = (t_q < 6'd16) ? w_q[0] : (w_q[0] + s0 + w_q[9] + s1);
		e1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + e1 + ch + round_k(t_q) + w_new;
		a0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = a0 + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			t_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				t_q <= '0;
			end else if (busy_q) begin
				t_q <= t_q + 6'd1;
				if (t_q == 6'(Rounds - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			for (int i = 0; i < 16; i++) w_q[i] <= block[511 - 32*i -: 32];
			for (int i = 0; i < 8; i++) v_q[i] <= chain[255 - 32*i -: 32];
		end else if (busy_q) begin
			// window shifts: w_new is w[t]; slot 0 holds w[t] for t < 16 and w[t-16] after
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_comb begin
		ctl_out.start = 1'b0;
		ctl_out.busy = busy_q;
		ctl_out.done = done_q;
		for (int i = 0; i < 8; i++) vars[255 - 32*i -: 32] = v_q[i];
	end
endmodule
`default_nettype wire

/* hdl/sha256_message_hasher_core.sv */
// sha-256 hasher core
// input channel: one transaction carries func, data_word (bytes big-endian,
// first byte in bits 31..24) and byte_count (0..4, 5..7 count as 4).
// func=0 only absorbs; func=1 absorbs, pads with 0x80, zeros and the 64-bit
// bit length, and returns eight digest transactions, word_index 0..7, with
// last_word on the eighth.
// bytes go one per cycle into the block buffer, except while a completed
// block is in the round unit; ready stays low until the item's bytes are in
// and any block it completes is compressed. the shared round unit, one
// round per cycle, sets the rate. a finish item adds up to two padded
// blocks (padding runs one byte per cycle between compressions) and then
// the eight output words.
// ready is low while an item is in work; the digest is held in the chain
// register and a stalled receiver simply holds each output word.
// reset: chain returns to the initial hash values, fill and bit count
// clear, no output pending. after a digest the same state is restored.
`default_nettype none
module sha256_message_hasher_core import sha_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	sha_in_if.sink    in_ch,
	sha_out_if.source out_ch
);
	state_t state_q, state_d;

	logic [511:0] block_q;    // byte shift register, first byte ends on top
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic [255:0] chain_q;
	logic [31:0]  data_q;
	logic [2:0]   left_q;
	logic         fin_q;
	logic [6:0]   pad_q;      // padding phase: 00 before 0x80, 01 zero-only block, 40 length block, 7f done
	logic         padding_q;  // set once padding started
	logic [2:0]   idx_q;
	logic [63:0]  len_q;

	round_ctl_t   rctl_in, rctl_out;
	logic [255:0] vars;

	sha_round u_round (
		.clk(clk), .arst_n(arst_n), .ctl_in(rctl_in), .block(block_q),
		.chain(chain_q), .ctl_out(rctl_out), .vars(vars)
	);

	logic       push;
	logic [7:0] push_byte;
	logic [2:0] nbytes;
	logic [7:0] pad_byte;

	assign nbytes = (in_ch.byte_count > 3'd4) ? 3'd4 : in_ch.byte_count;

	// padding byte for the current fill position
	always_comb begin
		if (!pad_q[6] && pad_q == 7'd0) pad_byte = 8'h80;
		else if (fill_q >= 6'd56 && pad_q[6]) pad_byte = len_q[63 - 8*(fill_q - 6'd56) -: 8];
		else pad_byte = 8'h00;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_ch.valid) state_d = ST_PACK;
			ST_PACK: begin
				if (left_q != 3'd0 && fill_q == 6'd63) state_d = ST_ROUND;
				else if (left_q == 3'd0) state_d = fin_q ? ST_PAD : ST_IDLE;
			end
			ST_ROUND: state_d = ST_FOLD;
			ST_FOLD: if (rctl_out.done)
				state_d = padding_q ? (pad_q[6] && fill_q == 6'd0 && pad_q == 7'h7f
					? ST_EMIT : ST_PAD) : ST_PACK;
			ST_PAD: if (fill_q == 6'd63) state_d = ST_ROUND;
			ST_EMIT: if (out_ch.ready && idx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		push = 1'b0;
		push_byte = 8'h00;
		rctl_in = '0;
		unique case (state_q)
			ST_PACK: begin
				push = (left_q != 3'd0);
				push_byte = data_q[31:24];
			end
			ST_PAD: begin
				push = 1'b1;
				push_byte = pad_byte;
			end
			ST_ROUND: rctl_in.start = 1'b1;
			default: ;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_EMIT);
	assign out_ch.digest_word = chain_q[255 - 32*idx_q -: 32];
	assign out_ch.word_index = idx_q;
	assign out_ch.last_word = (idx_q == 3'd7);

	always_ff @(posedge clk) if (push) block_q <= {block_q[503:0], push_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			bits_q <= '0;
			chain_q <= init_h();
			left_q <= '0;
			fin_q <= 1'b0;
			pad_q <= '0;
			padding_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (push) fill_q <= fill_q + 6'd1;
			if (state_q == ST_IDLE && in_ch.valid) begin
				data_q <= in_ch.data_word;
				left_q <= nbytes;
				fin_q <= in_ch.func;
				bits_q <= bits_q + {58'd0, nbytes, 3'd0};
				len_q <= bits_q + {58'd0, nbytes, 3'd0};
			end
			if (state_q == ST_PACK && left_q != 3'd0) begin
				data_q <= {data_q[23:0], 8'h00};
				left_q <= left_q - 3'd1;
			end
			if (state_q == ST_PAD) begin
				padding_q <= 1'b1;
				// pad_q[6] marks "length may go here" after the 0x80 byte;
				// 01 marks a zero-only block when no room is left for the length
				if (pad_q == 7'd0) pad_q <= (fill_q >= 6'd56) ? 7'h01 : 7'h40;
				if (pad_q[6] && fill_q == 6'd63) pad_q <= 7'h7f;
			end
			if (state_q == ST_FOLD && rctl_out.done) begin
				for (int i = 0; i < 8; i++)
					chain_q[255 - 32*i -: 32] <= chain_q[255 - 32*i -: 32] + vars[255 - 32*i -: 32];
				// zero-only block went out: the length goes in the next one
				if (pad_q == 7'h01) pad_q <= 7'h40;
			end
			if (state_q == ST_EMIT && out_ch.ready) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					chain_q <= init_h();
					fill_q <= '0;
					bits_q <= '0;
					pad_q <= '0;
					padding_q <= 1'b0;
					fin_q <= 1'b0;
				end
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/sha_checker.sv */
`default_nettype none
module sha_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [2:0] word_index,
	input wire logic last_word
);
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7))) else $error("last_word");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready)) else $error("ready while emitting");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=> out_valid && word_index == $past(word_index) + 3'd1)
		else $error("index");
endmodule
bind sha256_message_hasher_core sha_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .word_index(out_ch.word_index), .last_word(out_ch.last_word)
);
`default_nettype wire

/* tb/tb_if_stub.sv */
// the channel interfaces come with the rtl; this file carries the transaction types
package tb_sha_types;
	typedef struct packed {
		logic        func;
		logic [31:0] data_word;
		logic [2:0]  byte_count;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_item_t;
endpackage

/* tb/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tb_sha_types::*;

	localparam int CycleLimit = 400000;

	logic clk;
	logic arst_n;

	sha_in_if  in_ch();
	sha_out_if out_ch();

	sha256_message_hasher_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// round constants and initial hash values, kept locally for the predictor
	logic [31:0] kc [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
	logic [31:0] iv [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	// predictor state
	logic [31:0] hash_state [8];
	logic [7:0]  blk [64];
	int unsigned fill;
	logic [63:0] bit_len;

	msg_item_t    pending_msgs [$];
	digest_item_t expected_digest [$];
	int  errors;
	int  mismatches;
	int  digests_seen;
	int  finishes_sent;
	int  cycles;
	bit  stim_done;
	bit  hold_for_drain;
	bit  in_taken;

	function automatic logic [31:0] ror(logic [31:0] v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] a [8];
		logic [31:0] t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
				+ w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
		for (int i = 0; i < 8; i++) a[i] = hash_state[i];
		for (int t = 0; t < 64; t++) begin
			t1 = a[7] + (ror(a[4], 6) ^ ror(a[4], 11) ^ ror(a[4], 25))
				+ ((a[4] & a[5]) ^ (~a[4] & a[6])) + kc[t] + w[t];
			t2 = (ror(a[0], 2) ^ ror(a[0], 13) ^ ror(a[0], 22))
				+ ((a[0] & a[1]) ^ (a[0] & a[2]) ^ (a[1] & a[2]));
			a[7] = a[6]; a[6] = a[5]; a[5] = a[4]; a[4] = a[3] + t1;
			a[3] = a[2]; a[2] = a[1]; a[1] = a[0]; a[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] += a[i];
	endtask

	task automatic absorb_byte(logic [7:0] b);
		blk[fill] = b;
		fill++;
		if (fill == 64) begin
			compress_block();
			fill = 0;
		end
	endtask

	// predicted effect of one accepted transaction
	task automatic hash_msg_item(msg_item_t m);
		int n;
		logic [63:0] len;
		n = (m.byte_count > 4) ? 4 : m.byte_count;
		bit_len += 64'(n * 8);
		for (int i = 0; i < n; i++) absorb_byte(m.data_word[31-8*i -: 8]);
		if (m.func) begin
			len = bit_len;
			absorb_byte(8'h80);
			while (fill != 56) absorb_byte(8'h00);
			for (int i = 0; i < 8; i++) absorb_byte(len[63-8*i -: 8]);
			for (int i = 0; i < 8; i++)
				expected_digest.push_back('{hash_state[i], 3'(i), i == 7});
			for (int i = 0; i < 8; i++) hash_state[i] = iv[i];
			fill = 0;
			bit_len = 0;
		end
	endtask

	function automatic int gap_len();
		// mostly short gaps, now and then a long one
		if ($urandom_range(0, 9) < 4) return 0;
		if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_msg(logic func, logic [31:0] dw, logic [2:0] bc);
		pending_msgs.push_back('{func, dw, bc});
		if (func) finishes_sent++;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// stimulus: directed cases, then random messages
	initial begin
		int len;
		hash_state = iv;
		fill = 0;
		bit_len = 0;
		// empty message
		add_msg(1'b1, 32'h0, 3'd0);
		// "abc", unused low byte set to ones, must be ignored
		add_msg(1'b1, 32'h616263ff, 3'd3);
		// saturating byte counts, all-ones then all-zeros data
		add_msg(1'b0, 32'hffffffff, 3'd7);
		add_msg(1'b0, 32'h00000000, 3'd5);
		add_msg(1'b0, 32'h12345678, 3'd6);
		add_msg(1'b0, 32'hdeadbeef, 3'd1);
		add_msg(1'b0, 32'hcafef00d, 3'd2);
		add_msg(1'b1, 32'ha5a5a5a5, 3'd4);
		// 56 bytes: padding spills into a second block
		for (int i = 0; i < 14; i++) add_msg(1'b0, $urandom, 3'd4);
		add_msg(1'b1, 32'h0, 3'd0);
		while (pending_msgs.size() != 0) @(posedge clk);
		// random messages of mixed length, most short
		for (int m = 0; m < 16; m++) begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
			for (int i = 0; i < len; i++)
				add_msg(1'b0, $urandom, ($urandom_range(0, 5) == 0) ?
					3'($urandom_range(0, 7)) : 3'd4);
			add_msg(1'b1, $urandom, 3'($urandom_range(0, 7)));
			// once in the middle, hold the sender until all digests are in
			if (m == 6) begin
				while (pending_msgs.size() != 0) @(posedge clk);
				hold_for_drain = 1'b1;
				while (expected_digest.size() != 0) @(posedge clk);
				hold_for_drain = 1'b0;
			end
		end
		stim_done = 1'b1;
	end

	// driver
	int drive_gap;
	int out_gap;
	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.func = 1'b0;
		in_ch.data_word = '0;
		in_ch.byte_count = '0;
		out_ch.ready = 1'b0;
		drive_gap = 0;
		out_gap = 0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && !in_taken) begin
				// hold the transaction until it is taken
			end else begin
				in_taken = 1'b0;
				if (drive_gap > 0) begin
					in_ch.valid <= 1'b0;
					drive_gap <= drive_gap - 1;
				end else if (pending_msgs.size() != 0 && !hold_for_drain) begin
					in_ch.valid <= 1'b1;
					{in_ch.func, in_ch.data_word, in_ch.byte_count} <= pending_msgs[0];
					drive_gap <= gap_len();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
			if (out_gap > 0) begin
				out_ch.ready <= 1'b0;
				out_gap <= out_gap - 1;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 1) == 1) out_gap <= gap_len();
			end
		end
	end

	// acceptance of input transactions feeds the predictor
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready) begin
			hash_msg_item(pending_msgs.pop_front());
			in_taken = 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		digest_item_t got;
		digest_item_t exp_item;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.digest_word, out_ch.word_index, out_ch.last_word};
			digests_seen++;
			if (expected_digest.size() == 0) begin
				errors++;
				if (mismatches < 10)
					$display("unexpected digest transaction %h idx %0d last %b",
						got.digest_word, got.word_index, got.last_word);
				mismatches++;
			end else begin
				exp_item = expected_digest.pop_front();
				if (got !== exp_item) begin
					errors++;
					if (mismatches < 10)
						$display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
							exp_item.digest_word, exp_item.word_index, exp_item.last_word,
							got.digest_word, got.word_index, got.last_word);
					mismatches++;
				end
			end
		end
	end

	// end of run and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("sha256_message_hasher_core regression: fail");
			$finish;
		end
	end

	initial begin
		int settle;
		wait (stim_done);
		while (pending_msgs.size() != 0 || in_ch.valid) @(posedge clk);
		while (expected_digest.size() != 0) @(posedge clk);
		// settle period so that any stray output can show up
		settle = 0;
		while (settle < 300) begin
			@(posedge clk);
			settle++;
		end
		$display("covered %0d messages, %0d digest words, incl. empty, two-block pad,",
			finishes_sent, digests_seen);
		$display("saturating counts and random backpressure on both sides");
		if (errors == 0 && expected_digest.size() == 0) begin
			$display("sha256_message_hasher_core regression: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("sha256_message_hasher_core regression: fail");
		end
		$finish;
	end
endmodule
